[sv/rsf_pkg.sv]
// ----------------------------------------------------------------------------
// rsf_pkg: shared types and codes for the register scoreboard
// Request and instruction class codes, and the control bundle that the
// top level sends to every scoreboard entry.
// ----------------------------------------------------------------------------
package rsf_pkg;

    localparam int REG_IDX_W  = 5;
    localparam int TAG_PORT_W = 16;
    localparam int DATA_PORT_W = 32;

    typedef enum logic [2:0] {
        REQ_READY  = 3'd0,
        REQ_MARK   = 3'd1,
        REQ_EXEC   = 3'd2,
        REQ_MEM    = 3'd3,
        REQ_WB     = 3'd4,
        REQ_REMOVE = 3'd5,
        REQ_OPREAD = 3'd6
    } req_e_t;

    typedef enum logic [2:0] {
        CLS_R      = 3'd0,
        CLS_I      = 3'd1,
        CLS_LOAD   = 3'd2,
        CLS_STORE  = 3'd3,
        CLS_BRANCH = 3'd4,
        CLS_JUMP   = 3'd5
    } cls_e_t;

    // Per-cycle command broadcast to all entries
    typedef struct packed {
        logic mark_en;     // mark entries selected by hit_mark
        logic release_en;  // release entries owned by the tag
        logic keep_owner;  // free but keep owner (load after memory)
        logic fwd_set;     // forward data into the owned destination
        logic fwd_clear;   // drop the forward of the owned destination
    } rsf_ctrl_t;

endpackage

[sv/rsf_entry.sv]
// ----------------------------------------------------------------------------
// rsf_entry: one scoreboard entry
// Holds free bit, owner tag and forwarded value for one register, and
// matches the broadcast tag against its owner.
// ----------------------------------------------------------------------------
module rsf_entry
    import rsf_pkg::*;
#(
    parameter int TAG_WIDTH  = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  rsf_ctrl_t                    ctrl,
    input  logic                         hit_mark,
    input  logic                         hit_dest,
    input  logic [TAG_WIDTH-1:0]         tag,
    input  logic signed [DATA_WIDTH-1:0] data,
    output logic                         free,
    output logic                         owned,
    output logic                         fwd_present,
    output logic signed [DATA_WIDTH-1:0] fwd_data
);

    logic                         free_reg;
    logic                         owner_valid_reg;
    logic [TAG_WIDTH-1:0]         owner_tag_reg;
    logic                         fwd_present_reg;
    logic signed [DATA_WIDTH-1:0] fwd_data_reg;
    logic                         do_mark;
    logic                         do_release;

    assign owned      = owner_valid_reg && (owner_tag_reg == tag);
    assign do_mark    = ctrl.mark_en && hit_mark;
    assign do_release = ctrl.release_en && owned;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg        <= 1'b1;
            owner_valid_reg <= 1'b0;
            fwd_present_reg <= 1'b0;
        end
        else if (do_mark)
        begin
            free_reg        <= 1'b0;
            owner_valid_reg <= 1'b1;
        end
        else if (do_release)
        begin
            free_reg <= 1'b1;
            if (!ctrl.keep_owner)
            begin
                owner_valid_reg <= 1'b0;
            end
            if (hit_dest && ctrl.fwd_set)
            begin
                fwd_present_reg <= 1'b1;
            end
            else if (hit_dest && ctrl.fwd_clear)
            begin
                fwd_present_reg <= 1'b0;
            end
        end
    end

    // Payload: only read while its valid flag says so
    always_ff @(posedge clk)
    begin
        if (do_mark)
        begin
            owner_tag_reg <= tag;
        end
        if (do_release && hit_dest && ctrl.fwd_set)
        begin
            fwd_data_reg <= data;
        end
    end

    assign free        = free_reg;
    assign fwd_present = fwd_present_reg;
    assign fwd_data    = fwd_data_reg;

`ifndef SYNTHESIS
    // A busy register always has an owner
    a_busy_owned: assert property (@(posedge clk) disable iff (!rst_n)
        !free_reg |-> owner_valid_reg)
        else $error("busy entry without owner");

    // A forward appears only through a release of an owned destination
    a_fwd_from_owner: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fwd_present_reg) |-> $past(owned && ctrl.release_en && hit_dest))
        else $error("forward set on an entry not owned by the tag");
`endif

endmodule

[sv/register_scoreboard_forwarding.sv]
// ----------------------------------------------------------------------------
// register_scoreboard_forwarding: register hazard scoreboard with forwarding
// Tracks busy/free, owner tag and forwarded result per register, and answers
// readiness and operand queries.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive the request fields and pulse start. An item is
//   taken at each rising edge where start is high and busy is low; busy
//   stays low, so an item can enter every cycle.
//   Result channel: done is high for one cycle with ready_res, fwd_valid
//   and fwd_value. Every item gives exactly one result.
//   Pipeline: input register, then decode + entry update + result
//   register. Throughput: 1 item per cycle.
//   Each item updates the entry state at the same edge that registers its
//   result, so the following item already sees that update.
//   Releases compare the tag against all entries in parallel (one
//   comparator per entry), so release cost does not depend on NUM_REGS.
//   Reset: every register free, no owners, no forwards, pipeline empty.
//   The receiver cannot stall; results must be taken when done is high.
// ----------------------------------------------------------------------------
module register_scoreboard_forwarding
    import rsf_pkg::*;
#(
    parameter int NUM_REGS   = 32,
    parameter int TAG_WIDTH  = 16,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    req_type,
    input  logic [TAG_PORT_W-1:0]         instr_tag,
    input  logic [2:0]                    instr_class,
    input  logic [REG_IDX_W-1:0]          src1_reg,
    input  logic                          src1_used,
    input  logic [REG_IDX_W-1:0]          src2_reg,
    input  logic                          src2_used,
    input  logic [REG_IDX_W-1:0]          dest_reg,
    input  logic                          dest_used,
    input  logic signed [DATA_PORT_W-1:0] result_value,
    output logic                          done,
    output logic                          ready_res,
    output logic                          fwd_valid,
    output logic signed [DATA_PORT_W-1:0] fwd_value
);

    localparam int IDX_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int TAG_IN_W = (TAG_WIDTH < TAG_PORT_W) ? TAG_WIDTH : TAG_PORT_W;

    // Input register
    logic                          in_valid_reg;
    logic [2:0]                    req_reg;
    logic [TAG_PORT_W-1:0]         tag_in_reg;
    logic [2:0]                    cls_reg;
    logic [REG_IDX_W-1:0]          s1_reg;
    logic                          s1u_reg;
    logic [REG_IDX_W-1:0]          s2_reg;
    logic                          s2u_reg;
    logic [REG_IDX_W-1:0]          rd_reg;
    logic                          rdu_reg;
    logic signed [DATA_PORT_W-1:0] val_reg;

    // Result register
    logic                          done_reg;
    logic                          ready_res_reg;
    logic                          ready_res_next;
    logic                          fwd_valid_reg;
    logic                          fwd_valid_next;
    logic signed [DATA_PORT_W-1:0] fwd_value_reg;
    logic signed [DATA_PORT_W-1:0] fwd_value_next;

    // Decode
    logic [TAG_WIDTH-1:0]         tag_eff;
    logic signed [DATA_WIDTH-1:0] data_eff;
    logic                         s1_ok;
    logic                         s2_ok;
    logic                         rd_ok;
    logic                         s2_in_range;
    logic [IDX_W-1:0]             s1_idx;
    logic [IDX_W-1:0]             s2_idx;
    logic [IDX_W-1:0]             rd_idx;
    logic                         subst;
    logic                         avail1;
    logic                         avail2;
    logic                         r2_ok;
    logic [IDX_W-1:0]             r2_idx;
    logic [REG_IDX_W-1:0]         r2_reg;
    logic                         r2_used;
    logic                         r2_in_range;
    rsf_ctrl_t                    ctrl;

    // Entry status
    logic [NUM_REGS-1:0]          free_vec;
    logic [NUM_REGS-1:0]          owned_vec;
    logic [NUM_REGS-1:0]          fwdp_vec;
    logic signed [DATA_WIDTH-1:0] fwd_data_arr [NUM_REGS];

    assign busy = 1'b0;

    // Input register: capture the incoming item when it is accepted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg    <= req_type;
            tag_in_reg <= instr_tag;
            cls_reg    <= instr_class;
            s1_reg     <= src1_reg;
            s1u_reg    <= src1_used;
            s2_reg     <= src2_reg;
            s2u_reg    <= src2_used;
            rd_reg     <= dest_reg;
            rdu_reg    <= dest_used;
            val_reg    <= result_value;
        end
    end

    // Tag is compared in the narrower of the port and TAG_WIDTH;
    // data is sign-extended or cut to DATA_WIDTH.
    assign tag_eff  = TAG_WIDTH'(tag_in_reg[TAG_IN_W-1:0]);
    assign data_eff = DATA_WIDTH'(val_reg);

    // Registers past NUM_REGS count as absent
    assign s2_in_range = (32'(s2_reg) < NUM_REGS);
    assign s1_ok  = s1u_reg && (32'(s1_reg) < NUM_REGS);
    assign s2_ok  = s2u_reg && s2_in_range;
    assign rd_ok  = rdu_reg && (32'(rd_reg) < NUM_REGS);
    assign s1_idx = IDX_W'(s1_reg);
    assign s2_idx = IDX_W'(s2_reg);
    assign rd_idx = IDX_W'(rd_reg);

    // Ready query: the destination stands in for the second source on
    // I-type, load, store and branch.
    assign subst = (cls_reg == CLS_I) || (cls_reg == CLS_LOAD) ||
                   (cls_reg == CLS_STORE) || (cls_reg == CLS_BRANCH);
    assign r2_reg      = subst ? rd_reg : s2_reg;
    assign r2_used     = subst ? rdu_reg : s2u_reg;
    assign r2_in_range = (32'(r2_reg) < NUM_REGS);
    assign r2_ok       = r2_used && r2_in_range;
    assign r2_idx      = IDX_W'(r2_reg);

    // Register 0 and absent operands are always available
    assign avail1 = !s1_ok || (s1_reg == '0) || owned_vec[s1_idx] || free_vec[s1_idx];
    assign avail2 = !r2_ok || (r2_reg == '0) || owned_vec[r2_idx] || free_vec[r2_idx];

    // Turn the request into an entry command
    always_comb
    begin
        ctrl           = '0;
        ready_res_next = 1'b0;
        fwd_valid_next = 1'b0;
        fwd_value_next = '1;
        if (in_valid_reg)
        begin
            case (req_reg)
                REQ_READY:
                begin
                    ready_res_next = avail1 && avail2;
                end
                REQ_MARK:
                begin
                    ctrl.mark_en = 1'b1;
                end
                REQ_EXEC:
                begin
                    if ((cls_reg == CLS_BRANCH) || (cls_reg == CLS_JUMP))
                    begin
                        ctrl.release_en = 1'b1;
                    end
                    else if ((cls_reg != CLS_LOAD) && (cls_reg != CLS_STORE))
                    begin
                        ctrl.release_en = 1'b1;
                        ctrl.fwd_set    = 1'b1;
                    end
                end
                REQ_MEM:
                begin
                    if (cls_reg == CLS_LOAD)
                    begin
                        ctrl.release_en = 1'b1;
                        ctrl.keep_owner = 1'b1;
                        ctrl.fwd_set    = 1'b1;
                    end
                end
                REQ_WB:
                begin
                    if (cls_reg == CLS_STORE)
                    begin
                        ctrl.release_en = 1'b1;
                    end
                end
                REQ_REMOVE:
                begin
                    ctrl.release_en = 1'b1;
                    ctrl.fwd_clear  = (cls_reg != CLS_STORE) &&
                                      (cls_reg != CLS_BRANCH) &&
                                      (cls_reg != CLS_JUMP);
                end
                REQ_OPREAD:
                begin
                    // Operand read returns the forward only if its presence bit is set
                    if (s2_in_range && fwdp_vec[s2_idx])
                    begin
                        fwd_valid_next = 1'b1;
                        fwd_value_next = DATA_PORT_W'(fwd_data_arr[s2_idx]);
                    end
                end
                default:
                begin
                    ctrl = '0;
                end
            endcase
        end
    end

    // One entry per register; release matches the tag in every entry
    for (genvar i = 0; i < NUM_REGS; i++)
    begin : g_entry
        logic hit_mark;
        logic hit_dest;

        assign hit_dest = rd_ok && (rd_idx == IDX_W'(i));
        assign hit_mark = hit_dest ||
                          (s1_ok && (s1_idx == IDX_W'(i))) ||
                          ((cls_reg == CLS_R) && s2_ok && (s2_idx == IDX_W'(i)));

        rsf_entry #(
            .TAG_WIDTH  (TAG_WIDTH),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_entry (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .hit_mark    (hit_mark),
            .hit_dest    (hit_dest),
            .tag         (tag_eff),
            .data        (data_eff),
            .free        (free_vec[i]),
            .owned       (owned_vec[i]),
            .fwd_present (fwdp_vec[i]),
            .fwd_data    (fwd_data_arr[i])
        );
    end

    // Result register: strobe for exactly one cycle per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ready_res_reg <= ready_res_next;
        fwd_valid_reg <= fwd_valid_next;
        fwd_value_reg <= fwd_value_next;
    end

    assign done      = done_reg;
    assign ready_res = ready_res_reg;
    assign fwd_valid = fwd_valid_reg;
    assign fwd_value = fwd_value_reg;

`ifndef SYNTHESIS
    // Every accepted item produces its result strobe through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("result strobe missing for accepted item");

    // A result never reports both a readiness answer and a forward
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(ready_res && fwd_valid))
        else $error("ready and forward flags both set");

    // A forward is only reported for an operand read request
    a_fwd_req: assert property (@(posedge clk) disable iff (!rst_n)
        (done && fwd_valid) |-> $past(req_type == REQ_OPREAD, 2))
        else $error("forward reported for a request other than operand read");
`endif

endmodule
